// ===== rtl/core/vertex_affine_transform_core_defines.svh =====
// ----------------------------------------------------------------------------
// Vertex affine transform assertion macros
// Shared macros for concurrent checks; they compile away under synthesis.
// ----------------------------------------------------------------------------
`ifndef VERTEX_AFFINE_TRANSFORM_CORE_DEFINES_SVH
`define VERTEX_AFFINE_TRANSFORM_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define VAT_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vertex_affine_transform_core: same-cycle check failed");

`define VAT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vertex_affine_transform_core: next-cycle check failed");

`else

`define VAT_ASSERT_IMPL(label, clk, rst, ante, cons)

`define VAT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/vat_pkg.sv =====
// ----------------------------------------------------------------------------
// Vertex affine transform package
// Register indexes, mode codes, field widths and reset constants.
// ----------------------------------------------------------------------------
package vat_pkg;

  localparam int DATA_W    = 32;
  localparam int SCALE_W   = 31;
  localparam int TRIG_W    = 18;
  localparam int MODE_W    = 3;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_A_W  = 2 * DATA_W;
  localparam int PROD_B_W  = DATA_W + TRIG_W;

  typedef logic signed [DATA_W-1:0]   coord_t;
  typedef logic signed [PROD_A_W-1:0] prod_a_t;
  typedef logic signed [PROD_B_W-1:0] prod_b_t;
  typedef logic signed [TRIG_W-1:0]   trig_t;
  typedef logic        [SCALE_W-1:0]  scale_t;
  typedef logic        [MODE_W-1:0]   mode_code_t;

  localparam mode_code_t MODE_ADD    = 3'd0;
  localparam mode_code_t MODE_SUB    = 3'd1;
  localparam mode_code_t MODE_SCALE  = 3'd2;
  localparam mode_code_t MODE_ROT_X  = 3'd3;
  localparam mode_code_t MODE_ROT_Y  = 3'd4;
  localparam mode_code_t MODE_ROT_Z  = 3'd5;
  localparam mode_code_t MODE_BOUNDS = 3'd6;

  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COS      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SIN      = 3'd6;

  localparam scale_t SCALE_RESET = 31'd65536;
  localparam trig_t  COS_RESET   = 18'sd65536;
  localparam trig_t  SIN_RESET   = 18'sd0;

  localparam coord_t  COORD_MAX = 32'sh7FFFFFFF;
  localparam coord_t  COORD_MIN = 32'sh80000000;
  localparam prod_a_t SAT_HI    = 64'sh000000007FFFFFFF;
  localparam prod_a_t SAT_LO    = 64'shFFFFFFFF80000000;

endpackage

// ===== rtl/core/vertex_affine_transform_core.sv =====
// ----------------------------------------------------------------------------
// Vertex affine transform core
// Stage one multiplies and registers each accepted item; stage two adds and saturates
// into the output registers. Throughput is one item per cycle while out_ready holds.
// Reset is synchronous; it empties both stages, clears the box, loads register defaults.
// ----------------------------------------------------------------------------
`include "vertex_affine_transform_core_defines.svh"

module vertex_affine_transform_core
  import vat_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  coord_t               x_in,
  input  coord_t               y_in,
  input  coord_t               z_in,
  input  logic                 first,
  output logic                 out_valid,
  input  logic                 out_ready,
  output coord_t               x_out,
  output coord_t               y_out,
  output coord_t               z_out
);

  mode_code_t mode;
  coord_t     offset_x;
  coord_t     offset_y;
  coord_t     offset_z;
  scale_t     scale;
  trig_t      cos_angle;
  trig_t      sin_angle;

  coord_t low_x;
  coord_t high_x;
  coord_t low_y;
  coord_t high_y;
  coord_t low_z;
  coord_t high_z;

  logic    s1_valid;
  coord_t  s1_x;
  coord_t  s1_y;
  coord_t  s1_z;
  prod_a_t pa_x;
  prod_a_t pa_y;
  prod_a_t pa_z;
  prod_b_t pb_x;
  prod_b_t pb_y;
  prod_b_t pb_z;

  logic    in_accept;
  logic    s1_move;
  coord_t  coef_a;
  coord_t  other_x;
  coord_t  other_y;
  coord_t  other_z;
  prod_a_t pa_x_next;
  prod_a_t pa_y_next;
  prod_a_t pa_z_next;
  prod_b_t pb_x_next;
  prod_b_t pb_y_next;
  prod_b_t pb_z_next;
  coord_t  mid_x;
  coord_t  mid_y;
  coord_t  mid_z;
  coord_t  x_out_next;
  coord_t  y_out_next;
  coord_t  z_out_next;

  function automatic coord_t sat_wide(input prod_a_t v);
    coord_t r;
    if (v > SAT_HI) begin
      r = COORD_MAX;
    end else if (v < SAT_LO) begin
      r = COORD_MIN;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic coord_t sat_sum(input logic signed [DATA_W:0] v);
    coord_t r;
    if (v[DATA_W] != v[DATA_W-1]) begin
      r = v[DATA_W] ? COORD_MIN : COORD_MAX;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic coord_t midpoint(input coord_t lo, input coord_t hi);
    logic signed [DATA_W:0] s;
    s = {lo[DATA_W-1], lo} + {hi[DATA_W-1], hi};
    return s[DATA_W:1];
  endfunction

  function automatic coord_t lane_calc(
    input mode_code_t m,
    input coord_t     v,
    input coord_t     off,
    input prod_a_t    pa,
    input prod_b_t    pb,
    input logic       rot_lane,
    input logic       sub,
    input logic       scale_zero,
    input coord_t     mid
  );
    prod_a_t pb_ext;
    prod_a_t sum;
    coord_t  r;
    r      = v;
    pb_ext = {{(PROD_A_W-PROD_B_W){pb[PROD_B_W-1]}}, pb};
    sum    = sub ? (pa - pb_ext) : (pa + pb_ext);
    case (m) inside
      MODE_ADD: begin
        r = sat_sum({v[DATA_W-1], v} + {off[DATA_W-1], off});
      end
      MODE_SUB: begin
        r = sat_sum({v[DATA_W-1], v} - {off[DATA_W-1], off});
      end
      MODE_SCALE: begin
        if (!scale_zero) begin
          r = sat_wide(pa >>> FRAC_BITS);
        end
      end
      MODE_ROT_X, MODE_ROT_Y, MODE_ROT_Z: begin
        if (rot_lane) begin
          r = sat_wide(sum >>> FRAC_BITS);
        end
      end
      MODE_BOUNDS: begin
        r = mid;
      end
      default: begin
        r = v;
      end
    endcase
    return r;
  endfunction

  assign s1_move   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_move;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_ADD;
      offset_x  <= '0;
      offset_y  <= '0;
      offset_z  <= '0;
      scale     <= SCALE_RESET;
      cos_angle <= COS_RESET;
      sin_angle <= SIN_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MODE:     mode      <= cfg_data[MODE_W-1:0];
        REG_OFFSET_X: offset_x  <= cfg_data;
        REG_OFFSET_Y: offset_y  <= cfg_data;
        REG_OFFSET_Z: offset_z  <= cfg_data;
        REG_SCALE:    scale     <= cfg_data[SCALE_W-1:0];
        REG_COS:      cos_angle <= cfg_data[TRIG_W-1:0];
        REG_SIN:      sin_angle <= cfg_data[TRIG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (mode == MODE_SCALE) begin
      coef_a = {1'b0, scale};
    end else begin
      coef_a = {{(DATA_W-TRIG_W){cos_angle[TRIG_W-1]}}, cos_angle};
    end
    other_x   = (mode == MODE_ROT_Y) ? z_in : y_in;
    other_y   = (mode == MODE_ROT_X) ? z_in : x_in;
    other_z   = (mode == MODE_ROT_X) ? y_in : x_in;
    pa_x_next = prod_a_t'(x_in) * prod_a_t'(coef_a);
    pa_y_next = prod_a_t'(y_in) * prod_a_t'(coef_a);
    pa_z_next = prod_a_t'(z_in) * prod_a_t'(coef_a);
    pb_x_next = prod_b_t'(other_x) * prod_b_t'(sin_angle);
    pb_y_next = prod_b_t'(other_y) * prod_b_t'(sin_angle);
    pb_z_next = prod_b_t'(other_z) * prod_b_t'(sin_angle);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
    if (in_accept) begin
      s1_x <= x_in;
      s1_y <= y_in;
      s1_z <= z_in;
      pa_x <= pa_x_next;
      pa_y <= pa_y_next;
      pa_z <= pa_z_next;
      pb_x <= pb_x_next;
      pb_y <= pb_y_next;
      pb_z <= pb_z_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_x  <= '0;
      high_x <= '0;
      low_y  <= '0;
      high_y <= '0;
      low_z  <= '0;
      high_z <= '0;
    end else if (in_accept && (mode == MODE_BOUNDS)) begin
      if (first) begin
        low_x  <= x_in;
        high_x <= x_in;
        low_y  <= y_in;
        high_y <= y_in;
        low_z  <= z_in;
        high_z <= z_in;
      end else begin
        if (x_in < low_x)  low_x  <= x_in;
        if (x_in > high_x) high_x <= x_in;
        if (y_in < low_y)  low_y  <= y_in;
        if (y_in > high_y) high_y <= y_in;
        if (z_in < low_z)  low_z  <= z_in;
        if (z_in > high_z) high_z <= z_in;
      end
    end
  end

  always_comb begin
    mid_x      = midpoint(low_x, high_x);
    mid_y      = midpoint(low_y, high_y);
    mid_z      = midpoint(low_z, high_z);
    x_out_next = lane_calc(mode, s1_x, offset_x, pa_x, pb_x, mode != MODE_ROT_X,
                           mode == MODE_ROT_Z, scale == '0, mid_x);
    y_out_next = lane_calc(mode, s1_y, offset_y, pa_y, pb_y, mode != MODE_ROT_Y,
                           mode == MODE_ROT_X, scale == '0, mid_y);
    z_out_next = lane_calc(mode, s1_z, offset_z, pa_z, pb_z, mode != MODE_ROT_Z,
                           mode == MODE_ROT_Y, scale == '0, mid_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s1_move) begin
      x_out <= x_out_next;
      y_out <= y_out_next;
      z_out <= z_out_next;
    end
  end

  `VAT_ASSERT_NEXT(a_s1_holds_on_stall, clk, rst,
                   s1_valid && out_valid && !out_ready, s1_valid)
  `VAT_ASSERT_NEXT(a_out_drains, clk, rst,
                   out_valid && out_ready && !s1_valid, !out_valid)
  `VAT_ASSERT_IMPL(a_box_ordered, clk, rst, 1'b1,
                   (low_x <= high_x) && (low_y <= high_y) && (low_z <= high_z))
  `VAT_ASSERT_NEXT(a_box_restart, clk, rst,
                   in_accept && (mode == MODE_BOUNDS) && first,
                   (low_x == high_x) && (low_y == high_y) && (low_z == high_z))

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// Vertex affine transform core testbench
// Streams vertices through the core under every mode and checks each result
// vertex against a cycle-free predictor of the transform and the running box.
// A short directed pass covers saturation, flooring, zero scale, the box
// restart and out-of-range trig values.
// Randomized blocks follow, each with a fresh register setting and one of four
// mixes of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vat_pkg::*;

  localparam int FRAC           = 16;
  localparam int LATENCY        = 2;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BLOCKS  = 26;
  localparam int BLOCK_ITEMS    = 40;

  localparam mode_code_t           MODE_PASS = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vertex_t;

  class transform_tracker;
    mode_code_t mode;
    coord_t     offset[3];
    scale_t     zoom;
    trig_t      cos_a;
    trig_t      sin_a;
    coord_t     box_lo[3];
    coord_t     box_hi[3];
    vertex_t    want_q[$];
    int         errors;
    int         matched;
    int         mode_hits[8];

    function new();
      int a;
      mode  = MODE_ADD;
      zoom  = SCALE_RESET;
      cos_a = COS_RESET;
      sin_a = SIN_RESET;
      for (a = 0; a < 3; a++) begin
        offset[a] = '0;
        box_lo[a] = '0;
        box_hi[a] = '0;
      end
      for (a = 0; a < 8; a++) mode_hits[a] = 0;
      errors  = 0;
      matched = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        REG_MODE:     mode      = data[MODE_W-1:0];
        REG_OFFSET_X: offset[0] = data;
        REG_OFFSET_Y: offset[1] = data;
        REG_OFFSET_Z: offset[2] = data;
        REG_SCALE:    zoom      = data[SCALE_W-1:0];
        REG_COS:      cos_a     = data[TRIG_W-1:0];
        REG_SIN:      sin_a     = data[TRIG_W-1:0];
        default: ;
      endcase
    endfunction

    function coord_t clamp(longint v);
      if (v > longint'(COORD_MAX)) return COORD_MAX;
      if (v < longint'(COORD_MIN)) return COORD_MIN;
      return coord_t'(v);
    endfunction

    function coord_t turn(coord_t a, longint ca, coord_t b, longint cb);
      longint sum;
      sum = longint'(a) * ca + longint'(b) * cb;
      return clamp(sum >>> FRAC);
    endfunction

    function void note_vertex(vertex_t p, logic restart);
      coord_t  v[3];
      coord_t  r[3];
      longint  c;
      longint  s;
      longint  z;
      vertex_t e;
      int      a;
      v[0] = p.x;
      v[1] = p.y;
      v[2] = p.z;
      r    = v;
      c    = longint'(cos_a);
      s    = longint'(sin_a);
      z    = longint'({33'b0, zoom});
      mode_hits[mode]++;
      case (mode)
        MODE_ADD:
          for (a = 0; a < 3; a++) r[a] = clamp(longint'(v[a]) + longint'(offset[a]));
        MODE_SUB:
          for (a = 0; a < 3; a++) r[a] = clamp(longint'(v[a]) - longint'(offset[a]));
        MODE_SCALE:
          if (zoom != '0) begin
            for (a = 0; a < 3; a++) r[a] = clamp((longint'(v[a]) * z) >>> FRAC);
          end
        MODE_ROT_X: begin
          r[1] = turn(v[1], c, v[2], -s);
          r[2] = turn(v[1], s, v[2], c);
        end
        MODE_ROT_Y: begin
          r[0] = turn(v[0], c, v[2], s);
          r[2] = turn(v[2], c, v[0], -s);
        end
        MODE_ROT_Z: begin
          r[0] = turn(v[0], c, v[1], -s);
          r[1] = turn(v[0], s, v[1], c);
        end
        MODE_BOUNDS:
          for (a = 0; a < 3; a++) begin
            if (restart) begin
              box_lo[a] = v[a];
              box_hi[a] = v[a];
            end else begin
              if (v[a] < box_lo[a]) box_lo[a] = v[a];
              if (v[a] > box_hi[a]) box_hi[a] = v[a];
            end
            r[a] = coord_t'((longint'(box_lo[a]) + longint'(box_hi[a])) >>> 1);
          end
        default: ;
      endcase
      e.x = r[0];
      e.y = r[1];
      e.z = r[2];
      want_q = {want_q, e};
    endfunction

    function bit axis_ok(string name, coord_t want, coord_t got);
      if (got === want) return 1'b1;
      $display("%0t: %s expected %0d (%h) got %0d (%h)", $time, name, want, want, got, got);
      return 1'b0;
    endfunction

    function void check_vertex(vertex_t got);
      vertex_t e;
      bit      ok;
      if (want_q.size() == 0) begin
        errors++;
        $display("%0t: result %h %h %h arrived with no vertex outstanding",
                 $time, got.x, got.y, got.z);
        return;
      end
      e  = want_q.pop_front();
      ok = axis_ok("x_out", e.x, got.x);
      ok = axis_ok("y_out", e.y, got.y) && ok;
      ok = axis_ok("z_out", e.z, got.z) && ok;
      if (ok) matched++;
      else errors++;
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  coord_t               x_in;
  coord_t               y_in;
  coord_t               z_in;
  logic                 first;
  logic                 out_valid;
  logic                 out_ready;
  coord_t               x_out;
  coord_t               y_out;
  coord_t               z_out;

  transform_tracker tracker = new();
  int send_idle_pct;
  int recv_stall_pct;
  int reg_writes;
  int quiet_cycles;

  vertex_affine_transform_core #(.FRAC_BITS(FRAC)) dut (.*);

  always #2 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) tracker.note_vertex(vertex_t'({x_in, y_in, z_in}), first);
      if (out_valid && out_ready) tracker.check_vertex(vertex_t'({x_out, y_out, z_out}));
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("FAIL vertex_affine_transform_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_idling(input int phase);
    case (phase)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
      default: begin send_idle_pct = 31; recv_stall_pct = 31; end
    endcase
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    tracker.write_reg(idx, data);
    reg_writes++;
    @(negedge clk);
  endtask

  task automatic close_writes();
    cfg_write <= 1'b0;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.want_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  task automatic send_vertex(input coord_t x, input coord_t y, input coord_t z, input logic f);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    x_in     <= x;
    y_in     <= y;
    z_in     <= z;
    first    <= f;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return coord_t'(int'($urandom_range(0, 32'h3FFFF)) - 32'sh20000);
      3: return -coord_t'($urandom_range(0, 1));
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic randomize_setup();
    int         pick;
    mode_code_t md;
    pick = $urandom_range(0, 11);
    md   = (pick > 7) ? MODE_BOUNDS : mode_code_t'(pick);
    write_reg(REG_MODE, ($urandom & ~32'h7) | DATA_W'(md));
    write_reg(REG_OFFSET_X, rand_coord());
    write_reg(REG_OFFSET_Y, rand_coord());
    write_reg(REG_OFFSET_Z, rand_coord());
    case ($urandom_range(0, 5))
      0: write_reg(REG_SCALE, 32'h0);
      1: write_reg(REG_SCALE, 32'hFFFF_FFFF);
      2, 3: write_reg(REG_SCALE, $urandom_range(1, 32'h40000));
      default: write_reg(REG_SCALE, $urandom);
    endcase
    case ($urandom_range(0, 5))
      0: begin
        write_reg(REG_COS, $urandom);
        write_reg(REG_SIN, $urandom);
      end
      1: begin
        write_reg(REG_COS, 32'sd65536);
        write_reg(REG_SIN, -32'sd65536);
      end
      2: begin
        write_reg(REG_COS, -32'sd65536);
        write_reg(REG_SIN, 32'sd65536);
      end
      default: begin
        write_reg(REG_COS, int'($urandom_range(0, 131072)) - 65536);
        write_reg(REG_SIN, int'($urandom_range(0, 131072)) - 65536);
      end
    endcase
    if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, $urandom);
    close_writes();
  endtask

  task automatic random_vertex(input int i);
    coord_t v[3];
    logic   f;
    int     a;
    for (a = 0; a < 3; a++) begin
      if (tracker.mode == MODE_BOUNDS && $urandom_range(0, 7) != 0)
        v[a] = coord_t'(int'($urandom_range(0, 32'hFFFFF)) - 32'sh80000);
      else
        v[a] = rand_coord();
    end
    if (tracker.mode == MODE_BOUNDS)
      f = (i == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 15) == 0);
    else
      f = $urandom_range(0, 1);
    send_vertex(v[0], v[1], v[2], f);
  endtask

  initial begin
    int blk;
    int i;
    int m;
    rst            = 1'b1;
    cfg_write      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    x_in           = '0;
    y_in           = '0;
    z_in           = '0;
    first          = 1'b0;
    out_ready      = 1'b0;
    reg_writes     = 0;
    quiet_cycles   = 0;
    set_idling(0);
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // The box starts from its reset value until an item restarts it.
    write_reg(REG_MODE, MODE_BOUNDS);
    close_writes();
    send_vertex(32'sd100, -32'sd200, 32'sd300, 1'b0);
    send_vertex(COORD_MAX, COORD_MIN, -32'sd1, 1'b0);
    send_vertex(COORD_MIN, COORD_MAX, 32'sd0, 1'b1);
    send_vertex(COORD_MAX, COORD_MIN, 32'sd7, 1'b0);

    settle();
    write_reg(REG_MODE, MODE_ADD);
    write_reg(REG_OFFSET_X, COORD_MAX);
    write_reg(REG_OFFSET_Y, COORD_MIN);
    write_reg(REG_OFFSET_Z, 32'hFFFF_FFFF);
    close_writes();
    send_vertex(COORD_MAX, COORD_MIN, COORD_MIN, 1'b1);
    send_vertex(COORD_MIN, COORD_MAX, 32'sd0, 1'b0);
    send_vertex(32'sd1, -32'sd1, COORD_MAX, 1'b0);

    settle();
    write_reg(REG_MODE, MODE_SUB);
    close_writes();
    send_vertex(COORD_MIN, COORD_MAX, COORD_MAX, 1'b0);
    send_vertex(COORD_MAX, COORD_MIN, 32'sd0, 1'b0);

    settle();
    write_reg(REG_MODE, MODE_SCALE);
    write_reg(REG_SCALE, 32'h0);
    close_writes();
    send_vertex(COORD_MAX, COORD_MIN, 32'sd123, 1'b0);
    settle();
    write_reg(REG_SCALE, 32'hFFFF_FFFF);
    close_writes();
    send_vertex(COORD_MAX, COORD_MIN, -32'sd1, 1'b0);
    send_vertex(32'sd1, -32'sd1, 32'sd65535, 1'b0);
    settle();
    write_reg(REG_SCALE, 32'h1);
    close_writes();
    send_vertex(-32'sd1, 32'sd1, -32'sd65536, 1'b0);

    // Trig values outside the unit range are used as raw 18-bit patterns.
    settle();
    write_reg(REG_COS, 32'h0001_FFFF);
    write_reg(REG_SIN, 32'hFFFE_0000);
    close_writes();
    for (m = MODE_ROT_X; m <= MODE_ROT_Z; m++) begin
      settle();
      write_reg(REG_MODE, m);
      close_writes();
      send_vertex(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
      send_vertex(COORD_MIN, COORD_MIN, -32'sd12345, 1'b1);
    end

    settle();
    write_reg(REG_MODE, MODE_PASS);
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    close_writes();
    send_vertex(32'sd1234, COORD_MIN, COORD_MAX, 1'b1);

    for (blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      settle();
      randomize_setup();
      set_idling(blk % 4);
      for (i = 0; i < BLOCK_ITEMS; i++) begin
        if (blk % 6 == 3 && i == BLOCK_ITEMS / 2) settle();
        random_vertex(i);
      end
    end

    settle();
    $display("Checked %0d result vertices, %0d mismatched, after %0d register writes.",
             tracker.matched, tracker.errors, reg_writes);
    $display("Items per mode: add %0d sub %0d scale %0d rot x %0d y %0d z %0d box %0d spare %0d.",
             tracker.mode_hits[MODE_ADD], tracker.mode_hits[MODE_SUB],
             tracker.mode_hits[MODE_SCALE], tracker.mode_hits[MODE_ROT_X],
             tracker.mode_hits[MODE_ROT_Y], tracker.mode_hits[MODE_ROT_Z],
             tracker.mode_hits[MODE_BOUNDS], tracker.mode_hits[MODE_PASS]);
    if (tracker.errors == 0) begin
      $display("PASS vertex_affine_transform_core");
    end else begin
      $display("FAIL vertex_affine_transform_core");
    end
    $finish;
  end

endmodule
